/* rtl/amo_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// amo_pkg
// Shared widths, operation codes and types of the atomic memory operation unit.
// ============================================================================
package amo_pkg;

    // Field widths of the request and response channels
    localparam int AMO_KIND_W    = 2;
    localparam int AMO_ADDR_W    = 10;
    localparam int AMO_OP_W      = 4;
    localparam int AMO_WORD_W    = 32;

    // Defaults and upper bounds of the storage parameters
    localparam int AMO_ADDR_BITS     = 10;
    localparam int AMO_DATA_WIDTH    = 32;
    localparam int AMO_ADDR_BITS_MAX = 20;
    localparam int AMO_DATA_MAX      = 64;

    // Request kinds
    localparam logic [AMO_KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [AMO_KIND_W-1:0] KIND_STORE = 2'd1;
    localparam logic [AMO_KIND_W-1:0] KIND_RMW   = 2'd2;
    localparam logic [AMO_KIND_W-1:0] KIND_CAS   = 2'd3;

    // Read-modify-write operations
    localparam logic [AMO_OP_W-1:0] OP_XCHG     = 4'd0;
    localparam logic [AMO_OP_W-1:0] OP_ADD      = 4'd1;
    localparam logic [AMO_OP_W-1:0] OP_SUB      = 4'd2;
    localparam logic [AMO_OP_W-1:0] OP_AND      = 4'd3;
    localparam logic [AMO_OP_W-1:0] OP_NAND     = 4'd4;
    localparam logic [AMO_OP_W-1:0] OP_OR       = 4'd5;
    localparam logic [AMO_OP_W-1:0] OP_XOR      = 4'd6;
    localparam logic [AMO_OP_W-1:0] OP_MAX      = 4'd7;
    localparam logic [AMO_OP_W-1:0] OP_MIN      = 4'd8;
    localparam logic [AMO_OP_W-1:0] OP_UMAX     = 4'd9;
    localparam logic [AMO_OP_W-1:0] OP_UMIN     = 4'd10;
    localparam logic [AMO_OP_W-1:0] OP_UINCWRAP = 4'd11;
    localparam logic [AMO_OP_W-1:0] OP_UDECWRAP = 4'd12;
    localparam logic [AMO_OP_W-1:0] OP_USUBCOND = 4'd13;
    localparam logic [AMO_OP_W-1:0] OP_USUBSAT  = 4'd14;
    localparam logic [AMO_OP_W-1:0] OP_FLOAT    = 4'd15;

    // Status from the update logic to the pipeline control
    typedef struct packed {
        logic wr_en;
        logic success;
        logic error;
    } t_amo_flags;

endpackage

/* rtl/amo_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// amo_if
// Valid/ready channels for atomic requests and their responses.
// ============================================================================
interface amo_req_if import amo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [AMO_KIND_W-1:0] kind;
    logic [AMO_ADDR_W-1:0] address;
    logic [AMO_OP_W-1:0]   rmw_op;
    logic [AMO_WORD_W-1:0] data_value;
    logic [AMO_WORD_W-1:0] desired_value;

    modport source (output valid, kind, address, rmw_op, data_value, desired_value,
                    input ready);
    modport sink   (input valid, kind, address, rmw_op, data_value, desired_value,
                    output ready);
endinterface

interface amo_rsp_if import amo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [AMO_WORD_W-1:0] old_value;
    logic                  success;
    logic                  error;

    modport source (output valid, old_value, success, error, input ready);
    modport sink   (input valid, old_value, success, error, output ready);
endinterface

/* rtl/amo_mem.sv */
`timescale 1ns / 1ps
// ============================================================================
// amo_mem
// Word store: one write port, one read port with registered read data.
// ============================================================================
module amo_mem import amo_pkg::*; #(
    parameter int ADDR_BITS  = AMO_ADDR_BITS,
    parameter int DATA_WIDTH = AMO_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_BITS-1:0]  i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_BITS-1:0]  i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/amo_alu.sv */
`timescale 1ns / 1ps
// ============================================================================
// amo_alu
// Update logic: new word and status for load, store, rmw and compare-exchange.
// ============================================================================
module amo_alu import amo_pkg::*; #(
    parameter int DATA_WIDTH = AMO_DATA_WIDTH
) (
    input  logic [AMO_KIND_W-1:0] i_kind,
    input  logic [AMO_OP_W-1:0]   i_op,
    input  logic [DATA_WIDTH-1:0] i_old,
    input  logic [DATA_WIDTH-1:0] i_operand,
    input  logic [DATA_WIDTH-1:0] i_desired,
    output logic [DATA_WIDTH-1:0] o_new,
    output t_amo_flags            o_flags
);

    logic [DATA_WIDTH-1:0] diff;
    logic                  u_ge;
    logic                  s_gt;
    logic [DATA_WIDTH-1:0] rmw_new;

    // Shared subtract and compares
    assign diff = i_old - i_operand;
    assign u_ge = (i_old >= i_operand);
    assign s_gt = ($signed(i_old) > $signed(i_operand));

    // Read-modify-write result
    always_comb begin
        case (i_op)
            OP_XCHG:     rmw_new = i_operand;
            OP_ADD:      rmw_new = i_old + i_operand;
            OP_SUB:      rmw_new = diff;
            OP_AND:      rmw_new = i_old & i_operand;
            OP_NAND:     rmw_new = ~(i_old & i_operand);
            OP_OR:       rmw_new = i_old | i_operand;
            OP_XOR:      rmw_new = i_old ^ i_operand;
            OP_MAX:      rmw_new = s_gt ? i_old : i_operand;
            OP_MIN:      rmw_new = s_gt ? i_operand : i_old;
            OP_UMAX:     rmw_new = (i_old > i_operand) ? i_old : i_operand;
            OP_UMIN:     rmw_new = (i_old <= i_operand) ? i_old : i_operand;
            OP_UINCWRAP: rmw_new = u_ge ? '0 : i_old + DATA_WIDTH'(1);
            OP_UDECWRAP: rmw_new = (i_old == '0 || i_old > i_operand)
                                   ? i_operand : i_old - DATA_WIDTH'(1);
            OP_USUBCOND: rmw_new = u_ge ? diff : i_old;
            OP_USUBSAT:  rmw_new = u_ge ? diff : '0;
            default:     rmw_new = i_old;
        endcase
    end

    // Write enable, written word and status per kind
    always_comb begin
        o_new   = i_operand;
        o_flags = '0;
        case (i_kind)
            KIND_LOAD: begin
                o_flags.wr_en = 1'b0;
            end
            KIND_STORE: begin
                o_flags.wr_en = 1'b1;
            end
            KIND_RMW: begin
                o_new = rmw_new;
                if (i_op == OP_FLOAT) begin
                    o_flags.error = 1'b1;
                end else begin
                    o_flags.wr_en = 1'b1;
                end
            end
            KIND_CAS: begin
                o_new = i_desired;
                if (i_old == i_operand) begin
                    o_flags.wr_en   = 1'b1;
                    o_flags.success = 1'b1;
                end
            end
            default: begin
                o_flags = '0;
            end
        endcase
    end

endmodule

/* rtl/atomic_memory_operation_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// atomic_memory_operation_unit
// Word memory with load, store, read-modify-write and compare-exchange.
// ============================================================================
//  Channel   Dir  Handshake     Payload
//  i_req     in   valid/ready   kind, address, rmw_op, data_value, desired_value
//  o_rsp     out  valid/ready   old_value, success, error
//
//  One request per cycle sustained while responses are taken.
//  Stage 1 reads the memory; stage 2 computes, writes back and loads the response
//  register. A write to the address read in the same cycle is forwarded.
//  After reset a clearing pass zeroes all 2^ADDR_BITS words (1024 by default),
//  with i_req.ready low.
//  A stalled response holds stage 2; stage 1 then holds its request and data.
// ============================================================================
module atomic_memory_operation_unit import amo_pkg::*; #(
    parameter int ADDR_BITS  = AMO_ADDR_BITS,
    parameter int DATA_WIDTH = AMO_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    amo_req_if.sink   i_req,
    amo_rsp_if.source o_rsp
);

    // Clearing pass state
    logic                  r_clearing;
    logic [ADDR_BITS-1:0]  r_clr_addr;

    // Stage 1: request waiting on read data
    logic                  r_s1_valid;
    logic [AMO_KIND_W-1:0] r_s1_kind;
    logic [ADDR_BITS-1:0]  r_s1_addr;
    logic [AMO_OP_W-1:0]   r_s1_op;
    logic [DATA_WIDTH-1:0] r_s1_data;
    logic [DATA_WIDTH-1:0] r_s1_desired;
    logic                  r_fwd_hit;
    logic [DATA_WIDTH-1:0] r_fwd_data;

    // Response register
    logic                  r_out_valid;
    logic [AMO_WORD_W-1:0] r_out_old;
    logic                  r_out_success;
    logic                  r_out_error;

    logic                  req_fire;
    logic                  s1_advance;
    logic [ADDR_BITS-1:0]  req_addr;
    logic [DATA_WIDTH-1:0] req_data;
    logic [DATA_WIDTH-1:0] req_desired;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] old_word;
    logic [DATA_WIDTH-1:0] new_word;
    t_amo_flags            flags;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AMO_DATA_MAX-1:0]      data_wide;
    logic [AMO_DATA_MAX-1:0]      desired_wide;
    logic [AMO_ADDR_BITS_MAX-1:0] addr_wide;

    // Field width adaptation: cut or zero-extend to the storage widths
    assign data_wide    = AMO_DATA_MAX'(i_req.data_value);
    assign desired_wide = AMO_DATA_MAX'(i_req.desired_value);
    assign addr_wide    = AMO_ADDR_BITS_MAX'(i_req.address);
    assign req_data     = data_wide[DATA_WIDTH-1:0];
    assign req_desired  = desired_wide[DATA_WIDTH-1:0];
    assign req_addr     = addr_wide[ADDR_BITS-1:0];

    // Handshake control
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_clearing && (!r_s1_valid || s1_advance);
    assign req_fire    = i_req.valid && i_req.ready;

    // Old word, with forwarding of the write that overlapped the read
    assign old_word = r_fwd_hit ? r_fwd_data : rd_data;

    amo_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_kind    (r_s1_kind),
        .i_op      (r_s1_op),
        .i_old     (old_word),
        .i_operand (r_s1_data),
        .i_desired (r_s1_desired),
        .o_new     (new_word),
        .o_flags   (flags)
    );

    // Write port: clearing pass or stage 2 write-back
    assign mem_we    = r_clearing || (s1_advance && flags.wr_en);
    assign mem_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = r_clearing ? '0 : new_word;

    amo_mem #(
        .ADDR_BITS  (ADDR_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (req_fire),
        .i_raddr (req_addr),
        .o_rdata (rd_data)
    );

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload and forwarding capture
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_kind    <= i_req.kind;
            r_s1_addr    <= req_addr;
            r_s1_op      <= i_req.rmw_op;
            r_s1_data    <= req_data;
            r_s1_desired <= req_desired;
            r_fwd_hit    <= s1_advance && flags.wr_en && (r_s1_addr == req_addr);
            r_fwd_data   <= new_word;
        end
    end

    // Response register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response payload; store returns zero
    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_old     <= (r_s1_kind == KIND_STORE) ? '0 : AMO_WORD_W'(old_word);
            r_out_success <= flags.success;
            r_out_error   <= flags.error;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.old_value = r_out_old;
    assign o_rsp.success   = r_out_success;
    assign o_rsp.error     = r_out_error;

endmodule

/* bench/tb_atomic_memory_operation_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_atomic_memory_operation_unit
// Self-checking bench for the atomic memory operation unit. A driver feeds
// loads, stores, read-modify-writes and compare-exchanges from a queue, with
// random gaps. A word-image predictor computes each response at acceptance.
// A monitor with random and long stalls checks the responses in order.
// ============================================================================
module tb_atomic_memory_operation_unit;
    import amo_pkg::*;

    localparam int N_RANDOM    = 1950;
    localparam int IDLE_LIMIT  = 4000;   // clearing pass, long hold-off, gaps
    localparam int DRAIN_WAIT  = 8;
    localparam int LONG_HOLD   = 200;
    localparam int HOLD_AT_RSP = 400;
    localparam int MEM_DEPTH   = 1 << AMO_ADDR_BITS;

    typedef logic [AMO_WORD_W-1:0] t_word;

    // One request as queued for the driver
    typedef struct {
        logic [AMO_KIND_W-1:0] kind;
        logic [AMO_ADDR_W-1:0] address;
        logic [AMO_OP_W-1:0]   rmw_op;
        t_word                 data_value;
        t_word                 desired_value;
        int unsigned           gap;      // idle cycles before offering it
        bit                    drain;    // wait for all responses first
    } t_amo_access;

    typedef struct {
        t_word old_value;
        logic  success;
        logic  error;
    } t_amo_result;

    logic i_clk;
    logic i_rst_n;

    amo_req_if req_if ();
    amo_rsp_if rsp_if ();

    atomic_memory_operation_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_amo_access pending_access_q [$];
    t_amo_result expected_result_q [$];
    t_word       mem_image [MEM_DEPTH];

    int          errors = 0;
    int unsigned rsp_count = 0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // New word written by a read-modify-write
    function automatic t_word rmw_new_word(logic [AMO_OP_W-1:0] op, t_word o, t_word u);
        case (op)
            OP_XCHG:     return u;
            OP_ADD:      return o + u;
            OP_SUB:      return o - u;
            OP_AND:      return o & u;
            OP_NAND:     return ~(o & u);
            OP_OR:       return o | u;
            OP_XOR:      return o ^ u;
            OP_MAX:      return ($signed(o) > $signed(u)) ? o : u;
            OP_MIN:      return ($signed(o) > $signed(u)) ? u : o;
            OP_UMAX:     return (o > u) ? o : u;
            OP_UMIN:     return (o <= u) ? o : u;
            OP_UINCWRAP: return (o >= u) ? t_word'(0) : o + 1'b1;
            OP_UDECWRAP: return (o == 0 || o > u) ? u : o - 1'b1;
            OP_USUBCOND: return (o >= u) ? o - u : o;
            default:     return (o < u) ? t_word'(0) : o - u;
        endcase
    endfunction

    // Apply one accepted request to the word image, return its response
    function automatic t_amo_result perform_access(t_amo_access a);
        t_amo_result r;
        t_word       old;
        old = mem_image[a.address];
        r.old_value = '0;
        r.success   = 1'b0;
        r.error     = 1'b0;
        case (a.kind)
            KIND_LOAD: r.old_value = old;
            KIND_STORE: mem_image[a.address] = a.data_value;
            KIND_RMW: begin
                r.old_value = old;
                if (a.rmw_op == OP_FLOAT)
                    r.error = 1'b1;
                else
                    mem_image[a.address] = rmw_new_word(a.rmw_op, old, a.data_value);
            end
            default: begin
                r.old_value = old;
                if (old == a.data_value) begin
                    mem_image[a.address] = a.desired_value;
                    r.success = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_access(logic [AMO_KIND_W-1:0] kind, logic [AMO_ADDR_W-1:0] address,
                              logic [AMO_OP_W-1:0] op, t_word data, t_word desired,
                              int unsigned gap, bit drain);
        t_amo_access a;
        a.kind          = kind;
        a.address       = address;
        a.rmw_op        = op;
        a.data_value    = data;
        a.desired_value = desired;
        a.gap           = gap;
        a.drain         = drain;
        pending_access_q = {pending_access_q, a};
    endtask

    // Often small values so compare-exchange hits often, plus extremes
    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_word'($urandom_range(0, 3));
            4: return 32'h8000_0000;
            5: return 32'hFFFF_FFFF;
            6: return 32'h7FFF_FFFF;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string field, t_word exp_val, t_word act_val);
        $error("%s: expected %h, got %h", field, exp_val, act_val);
        errors++;
    endtask

    // Driver: offers the head of the pending queue after its gap
    int unsigned gap_cnt;
    bit          gap_loaded;
    t_amo_result drv_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_loaded = 1'b0;
            foreach (mem_image[i]) mem_image[i] = '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                drv_rsp = perform_access(pending_access_q.pop_front());
                expected_result_q = {expected_result_q, drv_rsp};
                gap_loaded = 1'b0;
            end
            if (req_if.valid && !req_if.ready) begin
                // request still waiting, keep it stable
            end else if (pending_access_q.size() == 0) begin
                req_if.valid <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    gap_cnt    = pending_access_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pending_access_q[0].drain && expected_result_q.size() != 0) begin
                    req_if.valid <= 1'b0;
                end else if (gap_cnt > 0) begin
                    gap_cnt--;
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid         <= 1'b1;
                    req_if.kind          <= pending_access_q[0].kind;
                    req_if.address       <= pending_access_q[0].address;
                    req_if.rmw_op        <= pending_access_q[0].rmw_op;
                    req_if.data_value    <= pending_access_q[0].data_value;
                    req_if.desired_value <= pending_access_q[0].desired_value;
                end
            end
        end
    end

    // Monitor: checks responses in order, stalls at random
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    t_amo_result exp_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_cnt = 0;
            hold_cnt  = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_result_q.size() == 0) begin
                    $error("response with no request outstanding: old_value %h",
                           rsp_if.old_value);
                    errors++;
                end else begin
                    exp_rsp = expected_result_q.pop_front();
                    if (rsp_if.old_value !== exp_rsp.old_value)
                        report_mismatch("old_value", exp_rsp.old_value, rsp_if.old_value);
                    if (rsp_if.success !== exp_rsp.success)
                        report_mismatch("success", t_word'(exp_rsp.success),
                                        t_word'(rsp_if.success));
                    if (rsp_if.error !== exp_rsp.error)
                        report_mismatch("error", t_word'(exp_rsp.error),
                                        t_word'(rsp_if.error));
                end
                rsp_count++;
                // every third stretch of 200 responses runs without stalls
                stall_cnt = ((rsp_count / 200) % 3 == 2) ? 0 : $urandom_range(0, 5);
                if (rsp_count == HOLD_AT_RSP)
                    hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rsp_if.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any handshake
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_atomic_memory_operation_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run
    logic [AMO_ADDR_W-1:0] last_addr;
    logic [AMO_ADDR_W-1:0] addr;
    logic [AMO_KIND_W-1:0] kind;
    int unsigned           pick;

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = KIND_LOAD;
        req_if.address       = '0;
        req_if.rmw_op        = OP_XCHG;
        req_if.data_value    = '0;
        req_if.desired_value = '0;
        rsp_if.ready         = 1'b0;

        // Directed: extremes, every operation and the boundary cases of each
        add_access(KIND_LOAD,  10'd0,    OP_FLOAT, $urandom, $urandom, 0, 0); // cleared word
        add_access(KIND_STORE, 10'd1023, OP_FLOAT, 32'hFFFF_FFFF, $urandom, 0, 0);
        add_access(KIND_LOAD,  10'd1023, OP_ADD,   $urandom, $urandom, 1, 0);
        add_access(KIND_RMW,   10'd1023, OP_ADD,   32'd1, $urandom, 0, 0);   // wraps to 0
        add_access(KIND_RMW,   10'd1023, OP_SUB,   32'd1, $urandom, 0, 0);   // wraps to all ones
        add_access(KIND_RMW,   10'd1023, OP_XCHG,  32'h8000_0000, $urandom, 2, 0);
        add_access(KIND_RMW,   10'd1023, OP_MAX,   32'h7FFF_FFFF, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_MIN,   32'h8000_0000, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_UMAX,  32'h7FFF_FFFF, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_UMIN,  32'h7FFF_FFFF, $urandom, 3, 0);
        add_access(KIND_RMW,   10'd1023, OP_AND,   32'h0F0F_0F0F, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_OR,    32'hF000_0000, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_XOR,   32'hFFFF_FFFF, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_NAND,  32'hFFFF_FFFF, $urandom, 5, 0);
        add_access(KIND_RMW,   10'd1023, OP_UINCWRAP, 32'hFFFF_FFFF, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_UINCWRAP, 32'd5, $urandom, 0, 0); // old >= operand
        add_access(KIND_RMW,   10'd1023, OP_UDECWRAP, 32'd9, $urandom, 0, 0); // old is zero
        add_access(KIND_RMW,   10'd1023, OP_UDECWRAP, 32'd9, $urandom, 0, 0); // plain decrement
        add_access(KIND_RMW,   10'd1023, OP_UDECWRAP, 32'd3, $urandom, 1, 0); // old > operand
        add_access(KIND_RMW,   10'd1023, OP_USUBCOND, 32'd5, $urandom, 0, 0); // no subtract
        add_access(KIND_RMW,   10'd1023, OP_USUBCOND, 32'd3, $urandom, 0, 0);
        add_access(KIND_RMW,   10'd1023, OP_USUBSAT,  32'd1, $urandom, 0, 0); // saturates
        add_access(KIND_RMW,   10'd1023, OP_FLOAT, 32'hFFFF_FFFF, $urandom, 0, 0); // error
        add_access(KIND_CAS,   10'd1023, OP_FLOAT, 32'd0, 32'hDEAD_BEEF, 0, 0); // match
        add_access(KIND_CAS,   10'd1023, OP_ADD,   32'd0, 32'h0000_0001, 0, 0); // no match

        // Random: hot addresses for back-to-back hazards, some full range
        last_addr = '0;
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                addr = AMO_ADDR_W'($urandom_range(0, 7));
            else if (pick == 6)
                addr = last_addr;
            else
                addr = AMO_ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
            last_addr = addr;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                kind = KIND_LOAD;
            else if (pick < 4)
                kind = KIND_STORE;
            else if (pick < 8)
                kind = KIND_RMW;
            else
                kind = KIND_CAS;
            add_access(kind, addr, AMO_OP_W'($urandom_range(0, 15)), pick_word(), pick_word(),
                       ((i / 150) % 3 == 1) ? 0 : $urandom_range(0, 5),
                       (i == 0 || i == N_RANDOM / 2));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_access_q.size() != 0 || expected_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0)
            $display("tb_atomic_memory_operation_unit OK");
        else
            $display("tb_atomic_memory_operation_unit NOT OK");
        $finish;
    end

endmodule
